### design/dds_am_pkg.sv
// Shared types, constants and the quarter-wave sine function for the
// DDS AM carrier modulator. No dependencies.
`timescale 1ns / 1ps

package dds_am_pkg;

    localparam int SINE_ADDR_BITS = 10;
    localparam int MAX_RATIO      = 64;
    localparam int INDEX_BITS     = 24;

    localparam int FRAC_BITS      = 16;
    localparam int LIM_BITS       = INDEX_BITS + FRAC_BITS;
    localparam int CNT_BITS       = $clog2(MAX_RATIO + 1);
    localparam int QTAB_LEN       = (1 << SINE_ADDR_BITS) + 1;
    localparam int ROM_ADDR_BITS  = SINE_ADDR_BITS + 1;

    localparam int PHASE_BITS     = 32;
    localparam int STEP_BITS      = 31;
    localparam int SPW_BITS       = 23;
    localparam int LEVEL_BITS     = 15;
    localparam int DEPTH_BITS     = 15;
    localparam int AMP_BITS       = 8;
    localparam int SIN_BITS       = 15;
    localparam int SAMPLE_BITS    = 17;
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 24;

    // mag = round(gain * sin / (255 * 2^15)), done as a shift then a
    // reciprocal multiply by ceil(2^32 / 255), exact for 24-bit dividends
    localparam int GAIN_BITS       = DEPTH_BITS + AMP_BITS;
    localparam int PROD_BITS       = GAIN_BITS + SIN_BITS;
    localparam int DEN_SHIFT       = 15;
    localparam int HALF_DEN        = 255 << (DEN_SHIFT - 1);
    localparam int QUOT_IN_BITS    = PROD_BITS + 1 - DEN_SHIFT;
    localparam int RECIP_BITS      = 25;
    localparam int RECIP_SHIFT     = 32;
    localparam int RECIP_PROD_BITS = QUOT_IN_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP_255 = 25'd16843010;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam int APB_ADDR_BITS  = 4;
    localparam int APB_DATA_BITS  = 32;

    localparam logic [STEP_BITS-1:0]  PHASE_STEP_RST = 31'd214748365;
    localparam logic [SPW_BITS-1:0]   SPW_RST        = 23'd756187;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RST      = 15'd16384;
    localparam logic [DEPTH_BITS-1:0] DEPTH_RST      = 15'd16384;

    typedef enum logic [1:0] {
        REG_PHASE_STEP,
        REG_SAMPLES_PER_WORD,
        REG_DC_OFFSET,
        REG_MOD_GAIN
    } reg_index_t;

    typedef struct packed {
        logic [STEP_BITS-1:0]  phase_step;
        logic [SPW_BITS-1:0]   samples_per_word;
        logic [LEVEL_BITS-1:0] dc_offset;
        logic [DEPTH_BITS-1:0] mod_gain;
    } cfg_t;

    // one classified item: samples to issue and whether the phase restarts
    typedef struct packed {
        logic [AMP_BITS-1:0] amplitude;
        logic [CNT_BITS-1:0] count;
        logic                phase_clear;
    } queue_entry_t;

    // sin(pi/2 * j / 2^SINE_ADDR_BITS) in Q0.15, Taylor series in Q30
    function automatic logic [SIN_BITS-1:0] sine_q15(input logic [ROM_ADDR_BITS-1:0] j);
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = 64'(j) << (30 - SINE_ADDR_BITS);
        t    = (x * 64'd1686629713) >> 30;
        t2   = (t * t) >> 30;
        sum  = t;
        term = ((t * t2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * t2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * t2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * t2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * t2) >> 30) / 64'd110;
        sum  = sum - term;
        r    = (sum + 64'd16384) >> 15;
        return (r > 64'd32767) ? 15'd32767 : r[SIN_BITS-1:0];
    endfunction

endpackage

### design/dds_am_regs.sv
// APB register file for the modulator settings.
// Depends on dds_am_pkg.
`timescale 1ns / 1ps

module dds_am_regs
    import dds_am_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t       cfg_reg;
    reg_index_t sel;
    logic       wr_en;

    assign sel    = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step       <= PHASE_STEP_RST;
            cfg_reg.samples_per_word <= SPW_RST;
            cfg_reg.dc_offset        <= LEVEL_RST;
            cfg_reg.mod_gain         <= DEPTH_RST;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_PHASE_STEP:       cfg_reg.phase_step       <= pwdata[STEP_BITS-1:0];
                REG_SAMPLES_PER_WORD: cfg_reg.samples_per_word <= pwdata[SPW_BITS-1:0];
                REG_DC_OFFSET:        cfg_reg.dc_offset        <= pwdata[LEVEL_BITS-1:0];
                REG_MOD_GAIN:         cfg_reg.mod_gain         <= pwdata[DEPTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_PHASE_STEP:       prdata = APB_DATA_BITS'(cfg_reg.phase_step);
            REG_SAMPLES_PER_WORD: prdata = APB_DATA_BITS'(cfg_reg.samples_per_word);
            REG_DC_OFFSET:        prdata = APB_DATA_BITS'(cfg_reg.dc_offset);
            REG_MOD_GAIN:         prdata = APB_DATA_BITS'(cfg_reg.mod_gain);
            default:              prdata = '0;
        endcase
    end

endmodule

### design/dds_am_front.sv
// Front end: accepts input items, advances the position limit and works out
// how many samples each item issues. Depends on dds_am_pkg.
`timescale 1ns / 1ps

module dds_am_front
    import dds_am_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [AMP_BITS-1:0] in_amplitude,
    input  logic                in_block_start,
    input  logic                in_block_end,
    input  logic [SPW_BITS-1:0] samples_per_word,
    output logic                push,
    output queue_entry_t        push_data,
    input  logic                queue_full
);

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } state_t;

    state_t                state_reg;
    logic [LIM_BITS-1:0]   limit_reg;
    logic [INDEX_BITS-1:0] index_reg;
    logic [AMP_BITS-1:0]   amp_reg;
    logic                  end_reg;
    logic                  pend_reset_reg;

    logic [LIM_BITS-1:0]   limit_next;
    logic [LIM_BITS-1:0]   diff;
    logic [INDEX_BITS-2:0] whole;
    logic                  frac_nz;
    logic [CNT_BITS-1:0]   count;
    logic                  accept;
    logic                  done;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid & in_ready;
    assign limit_next = (in_block_start ? '0 : limit_reg) + LIM_BITS'(samples_per_word);

    // distance from the next sample to the limit; top bit set means index ahead
    assign diff    = limit_reg - {index_reg, {FRAC_BITS{1'b0}}};
    assign whole   = diff[LIM_BITS-2:FRAC_BITS];
    assign frac_nz = |diff[FRAC_BITS-1:0];

    always_comb
    begin
        if (diff[LIM_BITS-1])
            count = '0;
        else if (whole >= (INDEX_BITS-1)'(MAX_RATIO))
            count = CNT_BITS'(MAX_RATIO);
        else if (end_reg)
            count = whole[CNT_BITS-1:0];     // last word drops the partial sample
        else
            count = whole[CNT_BITS-1:0] + CNT_BITS'(frac_nz);
    end

    // items with nothing to issue skip the queue; a phase restart waits
    assign push = (state_reg == ST_CALC) && (count != '0) && !queue_full;
    assign done = (state_reg == ST_CALC) && ((count == '0) || !queue_full);

    assign push_data.amplitude   = amp_reg;
    assign push_data.count       = count;
    assign push_data.phase_clear = pend_reset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_reg      <= '0;
            index_reg      <= '0;
            end_reg        <= 1'b0;
            pend_reset_reg <= 1'b0;
            amp_reg        <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        limit_reg <= limit_next;
                        amp_reg   <= in_amplitude;
                        end_reg   <= in_block_end;
                        if (in_block_start)
                        begin
                            index_reg      <= '0;
                            pend_reset_reg <= 1'b1;
                        end
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    if (done)
                    begin
                        index_reg <= index_reg + INDEX_BITS'(count);
                        if (push)
                            pend_reset_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### design/dds_am_fifo.sv
// Short queue of classified items between front and back end.
// Depends on dds_am_pkg.
`timescale 1ns / 1ps

module dds_am_fifo
    import dds_am_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_data,
    output logic         full,
    input  logic         pop,
    output queue_entry_t pop_data,
    output logic         empty
);

    queue_entry_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;

    assign full     = (count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue pop while empty");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue occupancy did not follow a push");

endmodule

### design/dds_am_back.sv
// Back end: issues one sample per cycle for each queued item, unless the
// output stalls, through the phase accumulator, sine ROM, gain multiply
// and rounding divide. Depends on dds_am_pkg.
`timescale 1ns / 1ps

module dds_am_back
    import dds_am_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          queue_empty,
    input  queue_entry_t                  queue_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic                          out_last
);

    logic [SIN_BITS-1:0]        sine_rom [QTAB_LEN];

    // issue stage
    logic [PHASE_BITS-1:0]      phase_reg;
    logic [CNT_BITS-1:0]        remain_reg;
    logic [GAIN_BITS-1:0]       gain_reg;
    // ROM stage
    logic                       v1_reg;
    logic [SIN_BITS-1:0]        sin1_reg;
    logic [1:0]                 quad1_reg;
    logic [GAIN_BITS-1:0]       gain1_reg;
    logic                       last1_reg;
    // product stage
    logic                       v2_reg;
    logic [PROD_BITS-1:0]       prod2_reg;
    logic [1:0]                 quad2_reg;
    logic                       last2_reg;
    // reciprocal stage
    logic                       v3_reg;
    logic [RECIP_PROD_BITS-1:0] recip3_reg;
    logic [1:0]                 quad3_reg;
    logic                       last3_reg;
    // output register
    logic                       out_valid_reg;
    logic [SAMPLE_BITS-1:0]     sample_reg;
    logic                       last_reg;

    logic                       en;
    logic                       issue;
    logic [1:0]                 quad;
    logic [SINE_ADDR_BITS-1:0]  j;
    logic [ROM_ADDR_BITS-1:0]   rom_addr;
    logic [PROD_BITS:0]         rounded;
    logic [QUOT_IN_BITS-1:0]    quot_in;
    logic [SAMPLE_BITS-1:0]     mag;
    logic [SAMPLE_BITS-1:0]     base;

    // quarter-wave table, constant entries folded at elaboration
    for (genvar g = 0; g < QTAB_LEN; g++)
    begin : g_sine_rom
        assign sine_rom[g] = sine_q15(ROM_ADDR_BITS'(g));
    end

    assign en    = !out_valid_reg || out_ready;
    assign issue = en && (remain_reg != '0);
    assign pop   = (remain_reg == '0) && !queue_empty;

    assign quad     = phase_reg[PHASE_BITS-1 -: 2];
    assign j        = phase_reg[PHASE_BITS-3 -: SINE_ADDR_BITS];
    // odd quadrants run the quarter wave backwards
    assign rom_addr = quad[0] ? ROM_ADDR_BITS'(QTAB_LEN - 1) - ROM_ADDR_BITS'(j)
                              : ROM_ADDR_BITS'(j);

    assign rounded = (PROD_BITS+1)'(prod2_reg) + (PROD_BITS+1)'(HALF_DEN);
    assign quot_in = rounded[PROD_BITS:DEN_SHIFT];
    assign mag     = SAMPLE_BITS'(recip3_reg >> RECIP_SHIFT);
    assign base    = SAMPLE_BITS'(cfg.dc_offset);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            remain_reg <= '0;
            gain_reg   <= '0;
        end
        else if (pop)
        begin
            remain_reg <= queue_data.count;
            gain_reg   <= cfg.mod_gain * queue_data.amplitude;
            if (queue_data.phase_clear)
                phase_reg <= '0;
        end
        else if (issue)
        begin
            remain_reg <= remain_reg - 1'b1;
            phase_reg  <= phase_reg + PHASE_BITS'(cfg.phase_step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin1_reg   <= sine_rom[rom_addr];
            quad1_reg  <= quad;
            gain1_reg  <= gain_reg;
            last1_reg  <= (remain_reg == CNT_BITS'(1));
            prod2_reg  <= gain1_reg * sin1_reg;
            quad2_reg  <= quad1_reg;
            last2_reg  <= last1_reg;
            recip3_reg <= quot_in * RECIP_255;
            quad3_reg  <= quad2_reg;
            last3_reg  <= last2_reg;
            sample_reg <= quad3_reg[1] ? base - mag : base + mag;
            last_reg   <= last3_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = signed'(sample_reg);
    assign out_last   = last_reg;

    a_remain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg <= CNT_BITS'(MAX_RATIO))
        else $error("sample count beyond the per-item limit");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (remain_reg == '0) && !issue)
        else $error("queue popped while an item is still issuing");
    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v3_reg))
        else $error("output valid without a sample in the pipe");

endmodule

### design/dds_am_carrier_modulator.sv
// Top level of the DDS AM carrier modulator: register file, front end,
// item queue and sample back end. Depends on dds_am_pkg and its submodules.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: amplitude; tuser: block_start;
//                                           tlast: block_end
//  m_axis    out  m_axis_tvalid/tready      tdata: sample (17b signed); tlast: last
//  apb       in   psel/penable/pwrite       paddr/pwdata/prdata, pready tied high
//
// The front end takes one item at a time and works out its sample count; it
// waits while the queue is full, unless the item has nothing to issue. The back
// end loads the next queue entry once an item is done, then issues one sample
// per cycle while the output is not stalled, through the sine ROM, gain multiply
// and reciprocal divide stages and the output register to m_axis_tvalid.
// Reset clears the phase, position and index state and loads register defaults.
// m_axis_tready low with a sample held stalls issue; the 4-entry queue still fills.
`timescale 1ns / 1ps

module dds_am_carrier_modulator
    import dds_am_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // [7:0] amplitude
    input  logic                      s_axis_tuser,   // [0] block_start
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,   // [16:0] sample, [23:17] zero
    output logic                      m_axis_tlast,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready
);

    cfg_t                          cfg;
    logic                          push;
    queue_entry_t                  push_data;
    logic                          queue_full;
    logic                          pop;
    queue_entry_t                  pop_data;
    logic                          queue_empty;
    logic signed [SAMPLE_BITS-1:0] sample;

    dds_am_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dds_am_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_axis_tvalid),
        .in_ready         (s_axis_tready),
        .in_amplitude     (s_axis_tdata[AMP_BITS-1:0]),
        .in_block_start   (s_axis_tuser),
        .in_block_end     (s_axis_tlast),
        .samples_per_word (cfg.samples_per_word),
        .push             (push),
        .push_data        (push_data),
        .queue_full       (queue_full)
    );

    dds_am_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    dds_am_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .queue_empty (queue_empty),
        .queue_data  (pop_data),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_sample  (sample),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_BITS'(unsigned'(sample));

endmodule
